### rtl/core/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and codes for the exit policy classifier pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epc_pkg;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_REJECTED = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN  = 2'd2;

    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;

    typedef struct packed {
        logic        func;
        logic [3:0]  rule_index;
        logic [31:0] rule_addr;
        logic [31:0] rule_mask;
        logic [15:0] rule_port_min;
        logic [15:0] rule_port_max;
        logic        rule_reject;
        logic [31:0] query_addr;
        logic [15:0] query_port;
    } t_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic       matched;
        logic [3:0] matched_index;
    } t_result;

    // summary of the first definite hit and of the maybe flags before it
    typedef struct packed {
        logic valid;
        logic any_hit;
        logic hit_reject;
        logic maybe_rej;
        logic maybe_acc;
    } t_prio_flags;

endpackage

### rtl/core/epc_rule_match.sv
// ----------------------------------------------------------------------------
// epc_rule_match
// Rule table and per-rule compare stage: all rules checked in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_rule_match #(
    parameter int MAX_RULES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  epc_pkg::t_item                i_item,
    input  logic [epc_pkg::COUNT_W-1:0]   i_rule_count,
    output logic                          o_valid,
    output logic [MAX_RULES-1:0]          o_hit,
    output logic [MAX_RULES-1:0]          o_maybe_rej,
    output logic [MAX_RULES-1:0]          o_maybe_acc,
    output logic [MAX_RULES-1:0]          o_reject
);

    logic [31:0] r_addr  [MAX_RULES];
    logic [31:0] r_mask  [MAX_RULES];
    logic [15:0] r_low   [MAX_RULES];
    logic [15:0] r_high  [MAX_RULES];
    logic [MAX_RULES-1:0] r_rej;

    logic                 r_valid;
    logic [MAX_RULES-1:0] r_hit;
    logic [MAX_RULES-1:0] r_mrej;
    logic [MAX_RULES-1:0] r_macc;
    logic [MAX_RULES-1:0] r_rej_q;

    logic [MAX_RULES-1:0] n_hit;
    logic [MAX_RULES-1:0] n_maybe;

    logic is_write;
    logic is_query;
    logic addr_unknown;
    logic port_unknown;

    assign is_write     = i_valid && (i_item.func == epc_pkg::FUNC_WRITE);
    assign is_query     = i_valid && (i_item.func == epc_pkg::FUNC_QUERY);
    assign addr_unknown = (i_item.query_addr == 32'd0);
    assign port_unknown = (i_item.query_port == 16'd0);

    // table write; index at or beyond the table size never matches a slot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RULES; i++) begin
            if (is_write && (int'(i_item.rule_index) == i)) begin
                r_addr[i] <= i_item.rule_addr;
                r_mask[i] <= i_item.rule_mask;
                r_low[i]  <= i_item.rule_port_min;
                r_high[i] <= i_item.rule_port_max;
                r_rej[i]  <= i_item.rule_reject;
            end
        end
    end

    always_comb begin
        logic in_range;
        logic addr_hit;
        logic mask_zero;
        logic enabled;
        n_hit   = '0;
        n_maybe = '0;
        for (int i = 0; i < MAX_RULES; i++) begin
            in_range  = (i_item.query_port >= r_low[i]) && (i_item.query_port <= r_high[i]);
            addr_hit  = ((i_item.query_addr & r_mask[i]) == (r_addr[i] & r_mask[i]));
            mask_zero = (r_mask[i] == 32'd0);
            enabled   = (i < int'(i_rule_count));
            if (addr_unknown) begin
                n_hit[i]   = enabled && in_range && mask_zero;
                n_maybe[i] = enabled && (in_range ? !mask_zero : port_unknown);
            end else begin
                n_hit[i]   = enabled && addr_hit && in_range;
                n_maybe[i] = enabled && addr_hit && !in_range && port_unknown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_mrej  <= n_maybe & r_rej;
        r_macc  <= n_maybe & ~r_rej;
        r_rej_q <= r_rej;
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_maybe_rej = r_mrej;
    assign o_maybe_acc = r_macc;
    assign o_reject    = r_rej_q;

    // a rule is a definite hit, a maybe or neither, never both
    a_hit_maybe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_hit & (r_mrej | r_macc)) == '0))
        else $error("rule flagged as both hit and maybe");

endmodule

### rtl/core/epc_prio.sv
// ----------------------------------------------------------------------------
// epc_prio
// First-hit isolation and maybe flags seen before the deciding rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_prio #(
    parameter int MAX_RULES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [MAX_RULES-1:0]  i_hit,
    input  logic [MAX_RULES-1:0]  i_maybe_rej,
    input  logic [MAX_RULES-1:0]  i_maybe_acc,
    input  logic [MAX_RULES-1:0]  i_reject,
    output epc_pkg::t_prio_flags  o_flags,
    output logic [MAX_RULES-1:0]  o_first
);

    logic [MAX_RULES-1:0] n_first;
    logic [MAX_RULES-1:0] n_earlier;

    logic                 r_valid;
    logic                 r_any_hit;
    logic                 r_hit_reject;
    logic                 r_maybe_rej;
    logic                 r_maybe_acc;
    logic [MAX_RULES-1:0] r_first;

    // lowest set bit; below it is everything evaluated earlier
    // with no hit, the mask wraps to all ones and covers every rule
    assign n_first   = i_hit & (~i_hit + MAX_RULES'(1));
    assign n_earlier = n_first - MAX_RULES'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first      <= n_first;
        r_any_hit    <= |i_hit;
        r_hit_reject <= |(n_first & i_reject);
        r_maybe_rej  <= |(i_maybe_rej & n_earlier);
        r_maybe_acc  <= |(i_maybe_acc & n_earlier);
    end

    always_comb begin
        o_flags.valid      = r_valid;
        o_flags.any_hit    = r_any_hit;
        o_flags.hit_reject = r_hit_reject;
        o_flags.maybe_rej  = r_maybe_rej;
        o_flags.maybe_acc  = r_maybe_acc;
    end

    assign o_first = r_first;

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($onehot0(r_first) && ((r_first != '0) == r_any_hit)))
        else $error("first hit vector not one-hot or inconsistent");

endmodule

### rtl/core/epc_verdict.sv
// ----------------------------------------------------------------------------
// epc_verdict
// Index encode and final verdict register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_verdict #(
    parameter int MAX_RULES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  epc_pkg::t_prio_flags  i_flags,
    input  logic [MAX_RULES-1:0]  i_first,
    output logic                  o_valid,
    output epc_pkg::t_result      o_result
);

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [IW-1:0]    idx;
    epc_pkg::t_result n_result;
    logic             r_valid;
    epc_pkg::t_result r_result;

    // one-hot to binary as an or of the set position
    always_comb begin
        idx = '0;
        for (int i = 0; i < MAX_RULES; i++) begin
            if (i_first[i]) begin
                idx = idx | IW'(i);
            end
        end
    end

    always_comb begin
        n_result.matched       = i_flags.any_hit;
        n_result.matched_index = epc_pkg::INDEX_W'(idx);
        if (i_flags.any_hit && i_flags.hit_reject) begin
            n_result.verdict = i_flags.maybe_acc ? epc_pkg::VERDICT_UNKNOWN
                                                 : epc_pkg::VERDICT_REJECTED;
        end else begin
            n_result.verdict = i_flags.maybe_rej ? epc_pkg::VERDICT_UNKNOWN
                                                 : epc_pkg::VERDICT_ACCEPTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_flags.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/core/exit_policy_classifier.sv
// a query passes the input register, the compare stage, the priority stage and the verdict register
// throughput: one item per cycle, writes and queries mixed freely; busy is always low
// a rule write lands in the table at the compare stage, so later queries see it
// the result strobe lasts one cycle and cannot be held off by the receiver
// reset clears the valid chain and the rule count; rule table contents are not reset
// ----------------------------------------------------------------------------
// exit_policy_classifier
// First-match accept/reject rule table for IPv4 address and port lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exit_policy_classifier #(
    parameter int MAX_RULES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  epc_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [epc_pkg::COUNT_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output epc_pkg::t_result             o_result
);

    logic                        r_valid;
    epc_pkg::t_item              r_item;
    logic [epc_pkg::COUNT_W-1:0] r_rule_count;

    logic                 m_valid;
    logic [MAX_RULES-1:0] m_hit;
    logic [MAX_RULES-1:0] m_mrej;
    logic [MAX_RULES-1:0] m_macc;
    logic [MAX_RULES-1:0] m_rej;

    epc_pkg::t_prio_flags p_flags;
    logic [MAX_RULES-1:0] p_first;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_rule_count <= '0;
        end else begin
            r_valid <= accept;
            if (i_cfg_we) begin
                r_rule_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= i_item;
    end

    epc_rule_match #(
        .MAX_RULES (MAX_RULES)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_valid),
        .i_item       (r_item),
        .i_rule_count (r_rule_count),
        .o_valid      (m_valid),
        .o_hit        (m_hit),
        .o_maybe_rej  (m_mrej),
        .o_maybe_acc  (m_macc),
        .o_reject     (m_rej)
    );

    epc_prio #(
        .MAX_RULES (MAX_RULES)
    ) u_prio (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (m_valid),
        .i_hit       (m_hit),
        .i_maybe_rej (m_mrej),
        .i_maybe_acc (m_macc),
        .i_reject    (m_rej),
        .o_flags     (p_flags),
        .o_first     (p_first)
    );

    epc_verdict #(
        .MAX_RULES (MAX_RULES)
    ) u_verdict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flags  (p_flags),
        .i_first  (p_first),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // every result traces back to an accepted query transfer
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && (i_item.func == epc_pkg::FUNC_QUERY), 4))
        else $error("result strobe without a matching query");

    a_default_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.matched) |-> (o_result.matched_index == '0))
        else $error("nonzero index on default verdict");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.verdict == epc_pkg::VERDICT_ACCEPTED ||
                     o_result.verdict == epc_pkg::VERDICT_REJECTED ||
                     o_result.verdict == epc_pkg::VERDICT_UNKNOWN))
        else $error("verdict outside defined codes");

    a_unknown_needs_maybe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p_flags.valid && !p_flags.maybe_rej && !p_flags.maybe_acc)
            |=> (o_result.verdict != epc_pkg::VERDICT_UNKNOWN))
        else $error("unknown verdict with no maybe hit before the decision");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the exit policy classifier: rule writes and address/port
// queries. A directed table comes first, then random rule sets under many
// rule counts. Results are checked against the table's expected values or
// else against a behavioral first-match classifier kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import epc_pkg::*;

    localparam int NUM_RULES  = 16;
    localparam int NUM_PLAN   = 17;
    localparam int NUM_PHASES = 12;
    localparam int QUIET_MAX  = 5000;
    localparam int SETTLE     = 8;
    localparam int ITEM_W     = $bits(t_item);

    typedef struct {
        logic        new_count;
        logic [4:0]  count;
        t_item       item;
        logic        typed;
        t_result     want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_item               i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]  i_cfg_wdata = '0;
    logic                o_valid;
    t_result             o_result;

    // shadow copy of the rule table and rule count
    logic [31:0] rule_addr_tbl [NUM_RULES];
    logic [31:0] rule_mask_tbl [NUM_RULES];
    logic [15:0] rule_lo_tbl   [NUM_RULES];
    logic [15:0] rule_hi_tbl   [NUM_RULES];
    logic        rule_rej_tbl  [NUM_RULES];
    logic [4:0]  active_rules = '0;

    t_result     verdicts_due [$];
    t_plan_row   plan [NUM_PLAN];

    int n_errors    = 0;
    int n_writes    = 0;
    int n_queries   = 0;
    int n_unknown   = 0;
    int n_defaulted = 0;
    int n_counts    = 0;
    int quiet       = 0;
    bit calm        = 1'b0;

    exit_policy_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #2 i_clk = ~i_clk;

    // first-match walk with maybe tracking for unknown address or port
    function automatic t_result classify(logic [31:0] qa, logic [15:0] qp);
        int      lim;
        logic    maybe_rej;
        logic    maybe_acc;
        logic    in_rng;
        logic    hit;
        logic    maybe;
        t_result r;
        lim = (active_rules > NUM_RULES) ? NUM_RULES : int'(active_rules);
        maybe_rej = 1'b0;
        maybe_acc = 1'b0;
        r = '0;
        for (int i = 0; i < lim; i++) begin
            in_rng = (qp >= rule_lo_tbl[i]) && (qp <= rule_hi_tbl[i]);
            hit = 1'b0;
            maybe = 1'b0;
            if (qa == 32'h0) begin
                if (in_rng) begin
                    if (rule_mask_tbl[i] == 32'h0)
                        hit = 1'b1;
                    else
                        maybe = 1'b1;
                end else if (qp == 16'h0) begin
                    maybe = 1'b1;
                end
            end else if ((qa & rule_mask_tbl[i]) == (rule_addr_tbl[i] & rule_mask_tbl[i])) begin
                if (in_rng)
                    hit = 1'b1;
                else if (qp == 16'h0)
                    maybe = 1'b1;
            end
            if (maybe) begin
                if (rule_rej_tbl[i])
                    maybe_rej = 1'b1;
                else
                    maybe_acc = 1'b1;
            end
            if (hit) begin
                if (rule_rej_tbl[i])
                    r.verdict = maybe_acc ? VERDICT_UNKNOWN : VERDICT_REJECTED;
                else
                    r.verdict = maybe_rej ? VERDICT_UNKNOWN : VERDICT_ACCEPTED;
                r.matched = 1'b1;
                r.matched_index = i[3:0];
                return r;
            end
        end
        r.verdict = maybe_rej ? VERDICT_UNKNOWN : VERDICT_ACCEPTED;
        return r;
    endfunction

    function automatic t_item mk_rule(logic [3:0] idx, logic [31:0] addr, logic [31:0] mask,
                                      logic [15:0] lo, logic [15:0] hi, logic rej);
        t_item it;
        it = '0;
        it.func = FUNC_WRITE;
        it.rule_index = idx;
        it.rule_addr = addr;
        it.rule_mask = mask;
        it.rule_port_min = lo;
        it.rule_port_max = hi;
        it.rule_reject = rej;
        return it;
    endfunction

    function automatic t_item mk_query(logic [31:0] addr, logic [15:0] port);
        t_item it;
        it = '0;
        it.func = FUNC_QUERY;
        it.query_addr = addr;
        it.query_port = port;
        return it;
    endfunction

    function automatic t_result res(logic [1:0] v, logic m, logic [3:0] idx);
        t_result r;
        r.verdict = v;
        r.matched = m;
        r.matched_index = idx;
        return r;
    endfunction

    // random rule drawn from a few networks and prefix lengths
    function automatic t_item rand_rule(logic [3:0] idx);
        t_item       it;
        int          plen;
        logic [31:0] base;
        logic [15:0] lo;
        logic [15:0] hi;
        case ($urandom_range(0, 5))
            0: plen = 0;
            1: plen = 8;
            2: plen = 16;
            3: plen = 24;
            4: plen = 32;
            default: plen = $urandom_range(1, 31);
        endcase
        case ($urandom_range(0, 4))
            0: base = 32'h0A00_0000;
            1: base = 32'hC0A8_0000;
            2: base = 32'hAC10_0000;
            3: base = 32'h0;
            default: base = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: begin lo = 16'h0;    hi = 16'hFFFF; end
            1: begin lo = 16'h0;    hi = 16'($urandom_range(1, 1023)); end
            2: begin lo = 16'($urandom_range(1, 1024)); hi = lo; end
            3: begin
                hi = 16'($urandom_range(0, 60000));
                lo = hi + 16'($urandom_range(1, 500));
            end
            4: begin
                lo = 16'($urandom_range(1, 65000));
                hi = lo + 16'($urandom_range(0, 535));
            end
            default: begin lo = 16'($urandom); hi = 16'($urandom); end
        endcase
        it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_WRITE;
        it.rule_index = idx;
        it.rule_addr = base | ($urandom & 32'h00FF_FFFF);
        it.rule_mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
        it.rule_port_min = lo;
        it.rule_port_max = hi;
        it.rule_reject = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // queries aimed at existing rules in nearly half the draws, with unknown address or port often
    function automatic t_item rand_query();
        t_item       it;
        int          r;
        logic [31:0] m;
        r = $urandom_range(0, NUM_RULES - 1);
        m = rule_mask_tbl[r];
        it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_QUERY;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: it.query_addr = 32'h0;
            5, 6, 7, 8, 9, 10, 11, 12, 13:
                it.query_addr = (rule_addr_tbl[r] & m) | ($urandom & ~m);
            14: it.query_addr = 32'hFFFF_FFFF;
            default: it.query_addr = $urandom;
        endcase
        r = $urandom_range(0, NUM_RULES - 1);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: it.query_port = 16'h0;
            5, 6: it.query_port = rule_lo_tbl[r];
            7, 8: it.query_port = rule_hi_tbl[r];
            9: it.query_port = rule_lo_tbl[r] - 16'd1;
            10: it.query_port = rule_hi_tbl[r] + 16'd1;
            11, 12, 13:
                it.query_port = 16'($urandom_range(rule_lo_tbl[r], rule_hi_tbl[r]));
            14: it.query_port = 16'hFFFF;
            default: it.query_port = 16'($urandom);
        endcase
        return it;
    endfunction

    // one transfer; the predictor runs at the accepting edge
    task automatic send(input t_item it, input logic typed, input t_result want);
        t_result r;
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.func == FUNC_WRITE) begin
            rule_addr_tbl[it.rule_index] = it.rule_addr;
            rule_mask_tbl[it.rule_index] = it.rule_mask;
            rule_lo_tbl[it.rule_index] = it.rule_port_min;
            rule_hi_tbl[it.rule_index] = it.rule_port_max;
            rule_rej_tbl[it.rule_index] = it.rule_reject;
            n_writes++;
        end else begin
            r = typed ? want : classify(it.query_addr, it.query_port);
            if (r.verdict == VERDICT_UNKNOWN)
                n_unknown++;
            if (!r.matched)
                n_defaulted++;
            verdicts_due.push_back(r);
            n_queries++;
        end
    endtask

    task automatic pace();
        if (!calm && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // rule count changes only with the pipeline empty
    task automatic set_rule_count(input logic [4:0] cnt);
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        active_rules = cnt;
        n_counts++;
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_result want;
            if (verdicts_due.size() == 0) begin
                $display("%0t unexpected result: verdict=%0d matched=%0b index=%0d",
                         $time, o_result.verdict, o_result.matched, o_result.matched_index);
                n_errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_result.verdict !== want.verdict || o_result.matched !== want.matched ||
                    o_result.matched_index !== want.matched_index) begin
                    $display({"%0t mismatch: expected verdict=%0d matched=%0b index=%0d,",
                              " got verdict=%0d matched=%0b index=%0d"},
                             $time, want.verdict, want.matched, want.matched_index,
                             o_result.verdict, o_result.matched, o_result.matched_index);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        while (quiet < QUIET_MAX) @(posedge i_clk);
        $display("%0t watchdog: no transfer for %0d cycles", $time, QUIET_MAX);
        $display("** exit_policy_classifier: FAILED **");
        $finish;
    end

    initial begin
        int n_items;
        // empty table, then a small rule set with an empty range and a catch-all
        plan[0]  = '{1'b0, 5'd0, mk_query(32'h0, 16'h0), 1'b1, res(VERDICT_ACCEPTED, 1'b0, 4'd0)};
        plan[1]  = '{1'b0, 5'd0, mk_query(32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                     res(VERDICT_ACCEPTED, 1'b0, 4'd0)};
        plan[2]  = '{1'b0, 5'd0, mk_rule(4'd0, 32'hC0A8_0000, 32'hFFFF_0000, 16'd1000, 16'd999,
                     1'b1), 1'b0, '0};
        plan[3]  = '{1'b0, 5'd0, mk_rule(4'd1, 32'h0A00_0000, 32'hFF00_0000, 16'd80, 16'd80, 1'b1),
                     1'b0, '0};
        plan[4]  = '{1'b0, 5'd0, mk_rule(4'd2, 32'h0, 32'h0, 16'h0, 16'hFFFF, 1'b0), 1'b0, '0};
        plan[5]  = '{1'b1, 5'd3, mk_query(32'hC0A8_0001, 16'd1000), 1'b1,
                     res(VERDICT_ACCEPTED, 1'b1, 4'd2)};
        // known address, unknown port, outside the range
        plan[6]  = '{1'b0, 5'd0, mk_query(32'hC0A8_0001, 16'h0), 1'b1,
                     res(VERDICT_UNKNOWN, 1'b1, 4'd2)};
        plan[7]  = '{1'b0, 5'd0, mk_query(32'h0A01_0203, 16'd80), 1'b1,
                     res(VERDICT_REJECTED, 1'b1, 4'd1)};
        // unknown address against a masked rule
        plan[8]  = '{1'b0, 5'd0, mk_query(32'h0, 16'd80), 1'b1, res(VERDICT_UNKNOWN, 1'b1, 4'd2)};
        plan[9]  = '{1'b0, 5'd0, mk_query(32'h0, 16'h0), 1'b0, '0};
        plan[10] = '{1'b1, 5'd2, mk_query(32'h0B00_0000, 16'd80), 1'b1,
                     res(VERDICT_ACCEPTED, 1'b0, 4'd0)};
        plan[11] = '{1'b0, 5'd0, mk_query(32'h0, 16'h0), 1'b1, res(VERDICT_UNKNOWN, 1'b0, 4'd0)};
        plan[12] = '{1'b0, 5'd0, mk_rule(4'd0, 32'h0A00_0000, 32'hFF00_0000, 16'd22, 16'd22, 1'b0),
                     1'b0, '0};
        plan[13] = '{1'b0, 5'd0, mk_rule(4'd1, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF, 1'b1),
                     1'b0, '0};
        // reject hit after a maybe-accept
        plan[14] = '{1'b0, 5'd0, mk_query(32'h0, 16'd22), 1'b1, res(VERDICT_UNKNOWN, 1'b1, 4'd1)};
        plan[15] = '{1'b0, 5'd0, mk_query(32'h0A00_0001, 16'd22), 1'b1,
                     res(VERDICT_ACCEPTED, 1'b1, 4'd0)};
        plan[16] = '{1'b0, 5'd0, mk_query(32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                     res(VERDICT_REJECTED, 1'b1, 4'd1)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].new_count)
                set_rule_count(plan[k].count);
            send(plan[k].item, plan[k].typed, plan[k].want);
            pace();
        end

        // fill the whole table before wider rule counts
        for (int i = 0; i < NUM_RULES; i++) begin
            send(rand_rule(i[3:0]), 1'b0, '0);
            pace();
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_rule_count(5'd16);
                1: set_rule_count(5'd0);
                2: set_rule_count(5'd1);
                3: set_rule_count(5'd31);
                4: set_rule_count(5'd17);
                default: set_rule_count(5'($urandom_range(0, 31)));
            endcase
            calm = (ph == 6);
            n_items = $urandom_range(120, 150);
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(0, 99) < 20)
                    send(rand_rule(4'($urandom_range(0, NUM_RULES - 1))), 1'b0, '0);
                else
                    send(rand_query(), 1'b0, '0);
                pace();
            end
        end

        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t %0d results never arrived", $time, verdicts_due.size());
            n_errors++;
        end

        $display("covered %0d rule writes and %0d queries over %0d rule count settings",
                 n_writes, n_queries, n_counts);
        $display("%0d queries ended unknown, %0d fell to the default, %0d errors",
                 n_unknown, n_defaulted, n_errors);
        if (n_errors == 0)
            $display("** exit_policy_classifier: PASSED **");
        else
            $display("** exit_policy_classifier: FAILED **");
        $finish;
    end

endmodule
